// ----- design/mrle_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mrle_pkg;

	// decoder phase, one-hot
	typedef enum logic [6:0] {
		PH_HEADER  = 7'b0000001,
		PH_DATA    = 7'b0000010,
		PH_COUNT   = 7'b0000100,
		PH_LONG_LO = 7'b0001000,
		PH_LONG_HI = 7'b0010000,
		PH_VALUE   = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

	// positions within the five-byte block header
	localparam logic [2:0] HDR_SIZE_LO = 3'd2;
	localparam logic [2:0] HDR_SIZE_HI = 3'd3;
	localparam logic [2:0] HDR_MARKER  = 3'd4;

	typedef struct packed {
		logic [7:0]  run_value;
		logic [15:0] run_length;
		logic        block_end;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

// ----- design/mrle_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mrle_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    stream_byte,
	input  wire logic [15:0]   block_total,
	output logic               res_valid,
	output mrle_pkg::res_t     res
);
	import mrle_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  header_index_q, header_index_d;
	logic [15:0] goal_q, goal_d;
	logic [16:0] decoded_q, decoded_d;
	logic [7:0]  marker_q, marker_d;
	logic [15:0] pending_q, pending_d;
	logic [15:0] blocks_q, blocks_d;

	logic        run_req;
	logic        empty_req;
	logic [7:0]  emit_value;
	logic [15:0] emit_length;
	logic [16:0] run_sum;
	logic        end_of_block;
	logic        fin;

	always_comb begin
		phase_d        = phase_q;
		header_index_d = header_index_q;
		goal_d         = goal_q;
		decoded_d      = decoded_q;
		marker_d       = marker_q;
		pending_d      = pending_q;
		blocks_d       = blocks_q;
		run_req        = 1'b0;
		empty_req      = 1'b0;
		emit_value     = stream_byte;
		emit_length    = 16'd1;
		end_of_block   = 1'b0;
		fin            = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				if (header_index_q == HDR_SIZE_LO) begin
					goal_d         = {8'h00, stream_byte};
					header_index_d = header_index_q + 3'd1;
				end else if (header_index_q == HDR_SIZE_HI) begin
					goal_d         = {stream_byte, goal_q[7:0]};
					header_index_d = header_index_q + 3'd1;
				end else if (header_index_q >= HDR_MARKER) begin
					marker_d       = stream_byte;
					decoded_d      = 17'd0;
					header_index_d = 3'd0;
					if (goal_q == 16'd0) begin
						empty_req   = 1'b1;
						emit_value  = 8'h00;
						emit_length = 16'd0;
					end else begin
						phase_d = PH_DATA;
					end
				end else begin
					header_index_d = header_index_q + 3'd1;
				end
			end
			PH_DATA: begin
				if (stream_byte == marker_q) begin
					phase_d = PH_COUNT;
				end else begin
					run_req = 1'b1;
				end
			end
			PH_COUNT: begin
				if (stream_byte != 8'h00) begin
					pending_d = {8'h00, stream_byte};
					phase_d   = PH_VALUE;
				end else begin
					phase_d = PH_LONG_LO;
				end
			end
			PH_LONG_LO: begin
				pending_d = {8'h00, stream_byte};
				phase_d   = PH_LONG_HI;
			end
			PH_LONG_HI: begin
				pending_d = {stream_byte, pending_q[7:0]};
				phase_d   = PH_VALUE;
			end
			PH_VALUE: begin
				phase_d     = PH_DATA;
				emit_length = pending_q;
				// a zero long count adds nothing and reports nothing
				run_req     = (pending_q != 16'd0);
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		run_sum = decoded_q + {1'b0, emit_length};
		if (run_req) begin
			decoded_d    = run_sum;
			end_of_block = (run_sum >= {1'b0, goal_q});
		end
		if (empty_req) begin
			end_of_block = 1'b1;
		end
		if ((run_req || empty_req) && end_of_block) begin
			blocks_d       = blocks_q + 16'd1;
			fin            = (blocks_d >= block_total);
			decoded_d      = 17'd0;
			header_index_d = 3'd0;
			phase_d        = fin ? PH_DONE : PH_HEADER;
		end
	end

	assign res_valid      = step && (run_req || empty_req);
	assign res.run_value  = emit_value;
	assign res.run_length = emit_length;
	assign res.block_end  = end_of_block;
	assign res.last       = fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			header_index_q <= 3'd0;
			goal_q         <= 16'd0;
			decoded_q      <= 17'd0;
			marker_q       <= 8'h00;
			pending_q      <= 16'd0;
			blocks_q       <= 16'd0;
		end else if (step) begin
			phase_q        <= phase_d;
			header_index_q <= header_index_d;
			goal_q         <= goal_d;
			decoded_q      <= decoded_d;
			marker_q       <= marker_d;
			pending_q      <= pending_d;
			blocks_q       <= blocks_d;
		end
	end

`ifndef SYNTHESIS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |-> !res_valid)
		else $error("result produced after the final block");

	a_header_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		header_index_q <= HDR_MARKER)
		else $error("header index beyond marker byte");

	a_empty_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.run_length == 16'd0) |-> res.block_end)
		else $error("zero-length result does not end its block");
`endif

endmodule

`default_nettype wire

// ----- design/marker_rle_block_decoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Marker-escaped run-length block decoder.
// Feed the packed stream on stream_byte with in_valid/in_ready, starting at
// the first block header. Each literal or finished run comes out on the
// output channel (out_valid/out_ready) as one run_value/run_length result;
// block_end marks the result that completes a block, last the one that
// completes the final block. Marker and count bytes give no result, nor do
// header bytes, but the last one of an empty block gives a zero-length
// result that ends it; bytes after the final block are consumed and dropped.
// The user must write block_count through block_count_we only while the
// unit is idle; the block itself does not enforce this. A value of zero
// decodes one block. Reset sets it to one. An accepted byte waits in the
// input register and is decoded when the decode stage advances, which loads
// its result into the result register; one byte per cycle passes while the
// receiver takes results. When the receiver stalls a pending result holds,
// the byte behind it waits in the input register and in_ready drops once
// that register is full. Reset clears the decoder to the first header byte
// of the first block and empties both registers.

module marker_rle_block_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        block_count_we,
	input  wire logic [15:0] block_count,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  stream_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       run_value,
	output logic [15:0]      run_length,
	output logic             block_end,
	output logic             last
);
	import mrle_pkg::*;

	logic [15:0] block_count_q;
	logic [15:0] block_total;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	res_t        res_s2;
	logic        advance;
	logic        core_valid;
	res_t        core_res;

	assign block_total = (block_count_q == 16'd0) ? 16'd1 : block_count_q;
	assign advance     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready    = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= 16'd1;
		end else if (block_count_we) begin
			block_count_q <= block_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= stream_byte;
		end
	end

	mrle_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.stream_byte (byte_s1),
		.block_total (block_total),
		.res_valid   (core_valid),
		.res         (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= core_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register loads only when the decode stage moves on
	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign out_valid  = valid_s2;
	assign run_value  = res_s2.run_value;
	assign run_length = res_s2.run_length;
	assign block_end  = res_s2.block_end;
	assign last       = res_s2.last;

`ifndef SYNTHESIS
	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> block_end)
		else $error("final-block flag without block end");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with an empty input register");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && core_valid) |=> out_valid)
		else $error("decoded result lost before the output register");
`endif

endmodule

`default_nettype wire
